FILE: rtl/core/ahp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahp_pkg
// Types, codes and helpers shared by the ack header parser and its checker.
// ----------------------------------------------------------------------------
package ahp_pkg;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_TOO_SHORT   = 2'd1,
        STATUS_NOT_REGULAR = 2'd2
    } ahp_status_t;

    typedef enum logic {
        PHASE_IDLE    = 1'b0,
        PHASE_COLLECT = 1'b1
    } ahp_phase_t;

    localparam logic [3:0]  MIN_HDR_RESET    = 4'd3;
    localparam logic [15:0] FULL_ACK_MIN_LEN = 16'd5;
    localparam logic [31:0] MASK_ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [3:0]  ACK_START_DELTA  = 4'd4;
    localparam logic [3:0]  ACK_START_FULL   = 4'd5;
    localparam logic [3:0]  HDR_BYTES_MIN    = 4'd4;
    localparam logic [3:0]  HDR_BYTES_MAX    = 4'd9;

    typedef struct packed {
        ahp_status_t status;
        logic [15:0] sequence_number;
        logic [15:0] ack_number;
        logic [31:0] ack_mask;
        logic [3:0]  header_bytes;
    } ahp_result_t;

    // Byte index at which the ack-bit bytes begin.
    function automatic logic [3:0] ack_bytes_start(input logic [7:0] prefix);
        return prefix[5] ? ACK_START_DELTA : ACK_START_FULL;
    endfunction

    // Total header length implied by the prefix byte.
    function automatic logic [3:0] full_header_len(input logic [7:0] prefix);
        return ack_bytes_start(prefix) + {3'b000, prefix[1]} + {3'b000, prefix[2]}
               + {3'b000, prefix[3]} + {3'b000, prefix[4]};
    endfunction

endpackage : ahp_pkg
`default_nettype wire

FILE: rtl/core/ack_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ack_header_parser
// Output: a result is pushed to the output buffer when the byte that ends the
// header (or the start byte that fails a check) is accepted; the parse logic
// is single-pass, taking one byte per cycle while the skid entry is empty.
// Reset: synchronous, active low; parser idle, minimum length back to 3.
// ----------------------------------------------------------------------------
module ack_header_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        s_start_of_packet,
    input  wire logic [15:0] s_packet_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_sequence_number,
    output logic [15:0]      m_ack_number,
    output logic [31:0]      m_ack_mask,
    output logic [3:0]       m_header_bytes
);
    import ahp_pkg::*;

    logic [3:0]  min_hdr_reg;
    ahp_phase_t  phase_reg,    phase_next;
    logic [3:0]  taken_reg,    taken_next;
    logic [7:0]  prefix_reg,   prefix_next;
    logic [15:0] seq_reg,      seq_next;
    logic [15:0] ack_reg,      ack_next;
    logic [31:0] mask_reg,     mask_next;

    logic        accept;
    logic        emit;
    ahp_result_t result;
    ahp_result_t out_data;
    ahp_status_t chk_status;
    logic [3:0]  lane_idx;
    logic [3:0]  lanes_seen;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hdr_reg <= MIN_HDR_RESET;
        end else if (cfg_we) begin
            min_hdr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_IDLE;
            taken_reg  <= '0;
            prefix_reg <= '0;
            seq_reg    <= '0;
            ack_reg    <= '0;
            mask_reg   <= MASK_ALL_ONES;
        end else if (accept) begin
            phase_reg  <= phase_next;
            taken_reg  <= taken_next;
            prefix_reg <= prefix_next;
            seq_reg    <= seq_next;
            ack_reg    <= ack_next;
            mask_reg   <= mask_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        taken_next  = taken_reg;
        prefix_next = prefix_reg;
        seq_next    = seq_reg;
        ack_next    = ack_reg;
        mask_next   = mask_reg;
        emit        = 1'b0;
        chk_status  = STATUS_OK;
        lane_idx    = taken_reg - ack_bytes_start(prefix_reg);
        lanes_seen  = '0;
        result      = '{status: STATUS_OK, sequence_number: '0, ack_number: '0,
                        ack_mask: '0, header_bytes: '0};

        if (s_start_of_packet) begin
            prefix_next = s_byte_value;
            taken_next  = 4'd1;
            seq_next    = '0;
            ack_next    = '0;
            mask_next   = MASK_ALL_ONES;
            if (s_packet_length < {12'd0, min_hdr_reg}) begin
                chk_status = STATUS_TOO_SHORT;
            end else if (s_byte_value[0]) begin
                chk_status = STATUS_NOT_REGULAR;
            end else if (!s_byte_value[5] && s_packet_length < FULL_ACK_MIN_LEN) begin
                chk_status = STATUS_TOO_SHORT;
            end else if (s_packet_length < {12'd0, full_header_len(s_byte_value)}) begin
                chk_status = STATUS_TOO_SHORT;
            end
            if (chk_status != STATUS_OK) begin
                phase_next    = PHASE_IDLE;
                emit          = 1'b1;
                result.status = chk_status;
            end else begin
                phase_next = PHASE_COLLECT;
            end
        end else if (phase_reg == PHASE_COLLECT) begin
            if (taken_reg == 4'd1) begin
                seq_next[7:0] = s_byte_value;
            end else if (taken_reg == 4'd2) begin
                seq_next[15:8] = s_byte_value;
            end else if (taken_reg == 4'd3 && prefix_reg[5]) begin
                ack_next = seq_reg - {8'd0, s_byte_value};
            end else if (taken_reg == 4'd3) begin
                ack_next[7:0] = s_byte_value;
            end else if (taken_reg == 4'd4 && !prefix_reg[5]) begin
                ack_next[15:8] = s_byte_value;
            end else begin
                for (int lane = 0; lane < 4; lane++) begin
                    if (prefix_reg[lane + 1]) begin
                        if (lanes_seen == lane_idx) begin
                            mask_next[lane*8 +: 8] = s_byte_value;
                        end
                        lanes_seen = lanes_seen + 4'd1;
                    end
                end
            end
            taken_next = taken_reg + 4'd1;
            if (taken_next >= full_header_len(prefix_reg)) begin
                phase_next = PHASE_IDLE;
                emit       = 1'b1;
                result     = '{status: STATUS_OK, sequence_number: seq_next,
                               ack_number: ack_next, ack_mask: mask_next,
                               header_bytes: taken_next};
            end
        end
    end

    ahp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && emit),
        .push_data (result),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_status          = out_data.status;
    assign m_sequence_number = out_data.sequence_number;
    assign m_ack_number      = out_data.ack_number;
    assign m_ack_mask        = out_data.ack_mask;
    assign m_header_bytes    = out_data.header_bytes;

endmodule : ack_header_parser
`default_nettype wire

FILE: rtl/core/ahp_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahp_out_buf
// Result register with one skid entry; the input side stays open while a
// single result waits for the consumer.
// ----------------------------------------------------------------------------
module ahp_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire ahp_pkg::ahp_result_t push_data,
    output logic                     can_push,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ahp_pkg::ahp_result_t     out_data
);
    import ahp_pkg::*;

    logic        out_valid_reg;
    ahp_result_t out_data_reg;
    logic        skid_valid_reg;
    ahp_result_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : ahp_out_buf
`default_nettype wire

FILE: rtl/core/ahp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahp_checker
// Port-level checks on the ack header parser result channel.
// ----------------------------------------------------------------------------
module ahp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [15:0] m_sequence_number,
    input wire logic [15:0] m_ack_number,
    input wire logic [31:0] m_ack_mask,
    input wire logic [3:0]  m_header_bytes
);
    import ahp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_sequence_number) && $stable(m_ack_number)
            && $stable(m_ack_mask) && $stable(m_header_bytes))
        else $error("result changed while stalled");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_header_bytes == 4'd0
            && m_sequence_number == 16'd0 && m_ack_number == 16'd0
            && m_ack_mask == 32'd0)
        else $error("error transaction carries nonzero fields");

    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_header_bytes >= HDR_BYTES_MIN
            && m_header_bytes <= HDR_BYTES_MAX)
        else $error("header length out of range");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STATUS_OK || m_status == STATUS_TOO_SHORT
            || m_status == STATUS_NOT_REGULAR)
        else $error("undefined status code");

    a_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("outputs not cleared by reset");

endmodule : ahp_checker

bind ack_header_parser ahp_checker u_ahp_checker (.*);
`default_nettype wire

FILE: test/ahp_header_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahp_header_checker
// Watches both channels of the ack header parser. Every accepted byte goes
// through a local header decoder that keeps its own parse state and minimum
// length. Each result transaction is checked field by field against the
// oldest decoded header still waiting.
// ----------------------------------------------------------------------------
module ahp_header_checker
    import ahp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        s_start_of_packet,
    input  wire logic [15:0] s_packet_length,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [15:0] m_sequence_number,
    input  wire logic [15:0] m_ack_number,
    input  wire logic [31:0] m_ack_mask,
    input  wire logic [3:0]  m_header_bytes,
    output int               fail_count,
    output int               pending_count,
    output int               checked_count
);

    logic [3:0]  min_len    = MIN_HDR_RESET;
    ahp_phase_t  cur_phase  = PHASE_IDLE;
    logic [3:0]  cur_taken  = '0;
    logic [7:0]  cur_prefix = '0;
    logic [15:0] cur_length = '0;
    logic [15:0] cur_seq    = '0;
    logic [15:0] cur_ack    = '0;
    logic [31:0] cur_mask   = MASK_ALL_ONES;

    ahp_result_t expected_headers[$];
    int          mismatches = 0;
    int          compared   = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    function automatic logic [3:0] header_length(input logic [7:0] prefix);
        logic [3:0] n;
        n = prefix[5] ? ACK_START_DELTA : ACK_START_FULL;
        for (int b = 1; b <= 4; b++) begin
            n = n + {3'b000, prefix[b]};
        end
        return n;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sop,
                               input logic [15:0] len);
        ahp_result_t r;
        logic [3:0]  k;
        logic [3:0]  lane_index;
        int          seen;
        bit          placed;
        r = '0;
        if (sop) begin
            cur_length = len;
            cur_prefix = b;
            cur_taken  = 4'd1;
            cur_seq    = '0;
            cur_ack    = '0;
            cur_mask   = MASK_ALL_ONES;
            r.status   = STATUS_OK;
            if (len < {12'd0, min_len}) begin
                r.status = STATUS_TOO_SHORT;
            end else if (b[0]) begin
                r.status = STATUS_NOT_REGULAR;
            end else if (!b[5] && len < FULL_ACK_MIN_LEN) begin
                r.status = STATUS_TOO_SHORT;
            end else if (len < {12'd0, header_length(b)}) begin
                r.status = STATUS_TOO_SHORT;
            end
            if (r.status != STATUS_OK) begin
                cur_phase = PHASE_IDLE;
                expected_headers.push_back(r);
            end else begin
                cur_phase = PHASE_COLLECT;
            end
        end else if (cur_phase == PHASE_COLLECT) begin
            k = cur_taken;
            if (k == 4'd1) begin
                cur_seq[7:0] = b;
            end else if (k == 4'd2) begin
                cur_seq[15:8] = b;
            end else if (k == 4'd3 && cur_prefix[5]) begin
                cur_ack = cur_seq - {8'd0, b};
            end else if (k == 4'd3) begin
                cur_ack[7:0] = b;
            end else if (k == 4'd4 && !cur_prefix[5]) begin
                cur_ack[15:8] = b;
            end else begin
                lane_index = k - (cur_prefix[5] ? ACK_START_DELTA : ACK_START_FULL);
                seen = 0;
                placed = 0;
                for (int lane = 0; lane < 4; lane++) begin
                    if (cur_prefix[lane + 1] && !placed) begin
                        if (seen == lane_index) begin
                            cur_mask[8 * lane +: 8] = b;
                            placed = 1;
                        end
                        seen++;
                    end
                end
            end
            cur_taken = k + 4'd1;
            if (cur_taken >= header_length(cur_prefix)) begin
                cur_phase         = PHASE_IDLE;
                r.status          = STATUS_OK;
                r.sequence_number = cur_seq;
                r.ack_number      = cur_ack;
                r.ack_mask        = cur_mask;
                r.header_bytes    = cur_taken;
                expected_headers.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        ahp_result_t want;
        if (!aresetn) begin
            min_len   = MIN_HDR_RESET;
            cur_phase = PHASE_IDLE;
            cur_taken = '0;
            cur_prefix = '0;
            cur_length = '0;
            cur_seq   = '0;
            cur_ack   = '0;
            cur_mask  = MASK_ALL_ONES;
            expected_headers.delete();
        end else begin
            if (cfg_we) begin
                min_len = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (expected_headers.size() == 0) begin
                    $error("result transaction with no header waiting: status 0x%0h",
                           m_status);
                    mismatches++;
                end else begin
                    want = expected_headers.pop_front();
                    check_field("status", {30'd0, want.status}, {30'd0, m_status});
                    check_field("sequence_number", {16'd0, want.sequence_number},
                                {16'd0, m_sequence_number});
                    check_field("ack_number", {16'd0, want.ack_number},
                                {16'd0, m_ack_number});
                    check_field("ack_mask", want.ack_mask, m_ack_mask);
                    check_field("header_bytes", {28'd0, want.header_bytes},
                                {28'd0, m_header_bytes});
                end
                compared++;
            end
            if (s_valid && s_ready) begin
                decode_byte(s_byte_value, s_start_of_packet, s_packet_length);
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_headers.size();
        checked_count <= compared;
    end

endmodule

FILE: test/tb_ack_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_header_parser
// Drives packet byte streams into the ack header parser: a directed set of
// header shapes and error cases, then random packets under several minimum
// length settings, with random idling on both channels. The checker beside
// the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_ack_header_parser;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 300;
    localparam int PHASE_ITEMS    = 218;
    localparam int NUM_SETTINGS   = 6;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        cfg_we            = 1'b0;
    logic [3:0]  cfg_wdata         = '0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value      = '0;
    logic        s_start_of_packet = 1'b0;
    logic [15:0] s_packet_length   = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_sequence_number;
    logic [15:0] m_ack_number;
    logic [31:0] m_ack_mask;
    logic [3:0]  m_header_bytes;

    int fail_count;
    int pending_count;
    int checked_count;

    bit calm            = 0;
    bit long_stall_req  = 0;
    int header_items    = 0;
    int ignored_items   = 0;
    int packets_sent    = 0;
    int idle_cycles     = 0;

    always #1 aclk = ~aclk;

    ack_header_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_start_of_packet (s_start_of_packet),
        .s_packet_length   (s_packet_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_sequence_number (m_sequence_number),
        .m_ack_number      (m_ack_number),
        .m_ack_mask        (m_ack_mask),
        .m_header_bytes    (m_header_bytes)
    );

    ahp_header_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_start_of_packet (s_start_of_packet),
        .s_packet_length   (s_packet_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_sequence_number (m_sequence_number),
        .m_ack_number      (m_ack_number),
        .m_ack_mask        (m_ack_mask),
        .m_header_bytes    (m_header_bytes),
        .fail_count        (fail_count),
        .pending_count     (pending_count),
        .checked_count     (checked_count)
    );

    // Offer one byte transaction and hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input logic sop,
                             input logic [15:0] len);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_byte_value      <= b;
        s_start_of_packet <= sop;
        s_packet_length   <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_packet();
        logic [7:0]  prefix;
        logic [3:0]  hdr;
        logic [15:0] len;
        int          kind;
        int          body;
        int          trail;
        kind   = $urandom_range(0, 99);
        prefix = 8'($urandom);
        prefix[0] = (kind < 5);
        hdr = (prefix[5] ? 4'd4 : 4'd5) + 4'($countones(prefix[4:1]));
        if (kind < 14) begin
            len = 16'($urandom_range(0, hdr));
        end else if (kind < 20) begin
            len = 16'($urandom_range(0, 65535));
        end else if (kind < 23) begin
            len = 16'hFFFF;
        end else begin
            len = 16'(hdr + $urandom_range(0, 40));
        end
        send_byte(prefix, 1'b1, len);
        header_items++;
        packets_sent++;
        body = hdr - 1;
        if (kind >= 90) begin
            body = $urandom_range(0, hdr - 2);
        end
        for (int i = 0; i < body; i++) begin
            send_byte(8'($urandom), 1'b0, 16'($urandom));
            header_items++;
        end
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < trail; i++) begin
            send_byte(8'($urandom), 1'b0, 16'($urandom));
            ignored_items++;
        end
    endtask

    // Drain all results, let the parser settle, then write the minimum length.
    task automatic write_min_length(input logic [3:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : receiver
        int  gap;
        bit  long_stall_done;
        long_stall_done = 0;
        wait (aresetn);
        forever begin
            if (long_stall_req && !long_stall_done) begin
                long_stall_done = 1;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            gap = calm ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [3:0] min_settings [NUM_SETTINGS];
        int         phase_start;
        min_settings[0] = 4'd0;
        min_settings[1] = 4'd15;
        min_settings[2] = 4'd1;
        min_settings[3] = 4'd9;
        min_settings[4] = 4'($urandom_range(2, 8));
        min_settings[5] = 4'd5;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // delta ack wrapping below zero
        send_byte(8'h20, 1'b1, 16'd4);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b0, 16'hFFFF);
        send_byte(8'h01, 1'b0, 16'h0000);
        // full ack, all four mask bytes, upper prefix bits set
        send_byte(8'hDE, 1'b1, 16'd9);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'h34, 1'b0, 16'hFFFF);
        send_byte(8'h12, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b0, 16'hFFFF);
        send_byte(8'h11, 1'b0, 16'h0000);
        send_byte(8'h22, 1'b0, 16'hFFFF);
        send_byte(8'hFF, 1'b0, 16'h0000);
        // below minimum, not regular, full ack too short, below header length
        send_byte(8'h20, 1'b1, 16'd2);
        send_byte(8'h01, 1'b1, 16'd100);
        send_byte(8'h00, 1'b1, 16'd4);
        send_byte(8'h3E, 1'b1, 16'd7);
        // stray byte while idle
        send_byte(8'hA5, 1'b0, 16'h5A5A);
        // unfinished header dropped by a new start
        send_byte(8'h20, 1'b1, 16'hFFFF);
        send_byte(8'h77, 1'b0, 16'h0000);
        send_byte(8'h22, 1'b1, 16'd5);
        send_byte(8'h10, 1'b0, 16'h0000);
        send_byte(8'h80, 1'b0, 16'h0000);
        send_byte(8'h05, 1'b0, 16'h0000);
        send_byte(8'h5A, 1'b0, 16'h0000);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_min_length(min_settings[p]);
            if (p == 2) begin
                long_stall_req = 1;
            end
            phase_start = header_items;
            while (header_items - phase_start < PHASE_ITEMS) begin
                calm = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    send_byte(8'($urandom), 1'b0, 16'($urandom));
                    ignored_items++;
                end
                send_packet();
            end
            calm = 0;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d packets, %0d header bytes and %0d ignored bytes",
                 packets_sent, header_items, ignored_items);
        $display("over %0d minimum length settings; %0d results compared",
                 NUM_SETTINGS + 1, checked_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ahp_pkg.sv
rtl/core/ahp_out_buf.sv
rtl/core/ack_header_parser.sv
rtl/core/ahp_checker.sv
test/ahp_header_checker.sv
test/tb_ack_header_parser.sv
